// File: src/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg: shared types and constants of the best-entry selector
// Field widths, candidate key type, leader summary type, register indexes
// and the ranking function.
// ----------------------------------------------------------------------------
package fbs_pkg;

  localparam int HANDLE_BITS = 16;

  localparam int HANDLE_W    = 16;
  localparam int CLUSTER_W   = 10;
  localparam int DIM_W       = 16;
  localparam int LEAF_W      = 5;
  localparam int PSUM_W      = 24;
  localparam int PRIMARY_W   = PSUM_W + DIM_W;
  localparam int SECONDARY_W = CLUSTER_W + LEAF_W;
  localparam int BOUND_W     = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BOUND_EXPONENT = 4'd0,
    CFG_WEIGHT_BY_DIM  = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [PRIMARY_W-1:0]   primary;
    logic [SECONDARY_W-1:0] secondary;
    logic [CLUSTER_W-1:0]   clusters;
  } cand_t;

  typedef struct packed {
    logic                   valid;
    logic [HANDLE_BITS-1:0] handle;
  } lead_t;

  // True when candidate a ranks strictly ahead of held candidate h.
  function automatic logic ranks_ahead(cand_t a, cand_t h);
    logic ahead;
    if (a.primary != h.primary) begin
      ahead = a.primary < h.primary;
    end else if (a.secondary != h.secondary) begin
      ahead = a.secondary < h.secondary;
    end else begin
      ahead = a.clusters > h.clusters;
    end
    return ahead;
  endfunction

endpackage

// File: src/fbs_in_if.sv
// ----------------------------------------------------------------------------
// fbs_in_if: candidate entry channel
// Valid/ready channel carrying one candidate entry per item.
// ----------------------------------------------------------------------------
interface fbs_in_if;
  logic                           valid;
  logic                           ready;
  logic [fbs_pkg::HANDLE_W-1:0]   entry_handle;
  logic [fbs_pkg::CLUSTER_W-1:0]  cluster_count;
  logic [fbs_pkg::DIM_W-1:0]      largest_dim;
  logic [fbs_pkg::LEAF_W-1:0]     leaf_limit;
  logic [fbs_pkg::PSUM_W-1:0]     dim_product_sum;
  logic                           final_entry;

  modport source (output valid, entry_handle, cluster_count, largest_dim, leaf_limit,
                  dim_product_sum, final_entry, input ready);
  modport sink   (input valid, entry_handle, cluster_count, largest_dim, leaf_limit,
                  dim_product_sum, final_entry, output ready);
endinterface

// File: src/fbs_out_if.sv
// ----------------------------------------------------------------------------
// fbs_out_if: selection result channel
// Valid/ready channel carrying one result item per finished set.
// ----------------------------------------------------------------------------
interface fbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [fbs_pkg::HANDLE_W-1:0] chosen_handle;
  logic                         met_property;
  logic                         nothing_left;

  modport source (output valid, chosen_handle, met_property, nothing_left, input ready);
  modport sink   (input valid, chosen_handle, met_property, nothing_left, output ready);
endinterface

// File: src/fbs_cfg_if.sv
// ----------------------------------------------------------------------------
// fbs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fbs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbs_pkg::CFG_INDEX_W-1:0] index;
  logic [fbs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/filtered_lexicographic_best_select_top.sv
// ----------------------------------------------------------------------------
// filtered_lexicographic_best_select_top: filtered best-entry selector
// Ranks candidate entries and reports the winner of each set.
// ----------------------------------------------------------------------------
// Accepts one candidate entry per clock cycle while entry.ready is high. An
// accepted item passes an input register, a key stage (bound filter,
// leaf-limit property and the two key products) and a leader-update stage
// that compares the candidate against the two held leaders once per cycle;
// the result item of a final entry is then registered in an output register.
// Entries keep flowing while the result waits unless the next final entry
// reaches the update stage. Configuration writes are taken at once.
// ----------------------------------------------------------------------------
module filtered_lexicographic_best_select_top (
  input logic       clk,
  input logic       rst,
  fbs_in_if.sink    entry,
  fbs_cfg_if.sink   cfg,
  fbs_out_if.source result
);

  logic [fbs_pkg::BOUND_W-1:0] bound_exponent;
  logic                        weight_by_dim;

  // input register
  logic                                s1_v;
  logic [fbs_pkg::HANDLE_BITS-1:0]     s1_handle;
  logic [fbs_pkg::CLUSTER_W-1:0]       s1_clusters;
  logic [fbs_pkg::DIM_W-1:0]           s1_dim;
  logic [fbs_pkg::LEAF_W-1:0]          s1_leaf;
  logic [fbs_pkg::PSUM_W-1:0]          s1_psum;
  logic                                s1_last;

  // key stage
  logic                                s2_v;
  logic                                s2_keep;
  logic                                s2_prop;
  logic                                s2_last;
  fbs_pkg::cand_t                      s2_cand;

  logic [fbs_pkg::PRIMARY_W-1:0]       prod;
  logic [fbs_pkg::SECONDARY_W-1:0]     sec;
  logic                                dropped;
  logic                                prop;

  logic                                out_v;
  logic [fbs_pkg::HANDLE_W-1:0]        out_handle;
  logic                                out_met;
  logic                                out_none;

  logic                                out_free;
  logic                                s2_go;
  logic                                s2_free;
  logic                                s1_go;
  logic                                s1_free;

  fbs_pkg::lead_t                      any_next;
  fbs_pkg::lead_t                      pref_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_exponent <= '0;
      weight_by_dim  <= 1'b0;
    end else if (cfg.valid) begin
      unique case (fbs_pkg::cfg_reg_t'(cfg.index))
        fbs_pkg::CFG_BOUND_EXPONENT: bound_exponent <= cfg.data[fbs_pkg::BOUND_W-1:0];
        fbs_pkg::CFG_WEIGHT_BY_DIM:  weight_by_dim  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // flow control: a stage advances when the stage after it has room
  assign out_free    = !out_v || result.ready;
  assign s2_go       = s2_v && (!s2_last || out_free);
  assign s2_free     = !s2_v || s2_go;
  assign s1_go       = s1_v && s2_free;
  assign s1_free     = !s1_v || s1_go;
  assign entry.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= entry.valid;
    end
    if (s1_free && entry.valid) begin
      s1_handle   <= fbs_pkg::HANDLE_BITS'(entry.entry_handle);
      s1_clusters <= entry.cluster_count;
      s1_dim      <= entry.largest_dim;
      s1_leaf     <= entry.leaf_limit;
      s1_psum     <= entry.dim_product_sum;
      s1_last     <= entry.final_entry;
    end
  end

  // dim >= 2^b exactly when some bit survives a right shift by b
  assign dropped = (bound_exponent != '0) && ((s1_dim >> bound_exponent) != '0);
  assign prop    = (s1_dim >> s1_leaf) == '0;
  assign prod    = weight_by_dim ?
                   fbs_pkg::PRIMARY_W'(s1_psum) * fbs_pkg::PRIMARY_W'(s1_dim) :
                   fbs_pkg::PRIMARY_W'(s1_psum);
  assign sec     = fbs_pkg::SECONDARY_W'(s1_clusters) * fbs_pkg::SECONDARY_W'(s1_leaf);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_v;
    end
    if (s1_go) begin
      s2_keep           <= !dropped;
      s2_prop           <= prop;
      s2_last           <= s1_last;
      s2_cand.handle    <= s1_handle;
      s2_cand.primary   <= prod;
      s2_cand.secondary <= sec;
      s2_cand.clusters  <= s1_clusters;
    end
  end

  fbs_leader u_any (
    .clk       (clk),
    .rst       (rst),
    .cand      (s2_cand),
    .take      (s2_go && s2_keep),
    .clear     (s2_go && s2_last),
    .next_lead (any_next)
  );

  fbs_leader u_pref (
    .clk       (clk),
    .rst       (rst),
    .cand      (s2_cand),
    .take      (s2_go && s2_keep && s2_prop),
    .clear     (s2_go && s2_last),
    .next_lead (pref_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s2_go && s2_last) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
    if (s2_go && s2_last) begin
      priority if (pref_next.valid) begin
        out_handle <= fbs_pkg::HANDLE_W'(pref_next.handle);
        out_met    <= 1'b1;
        out_none   <= 1'b0;
      end else if (any_next.valid) begin
        out_handle <= fbs_pkg::HANDLE_W'(any_next.handle);
        out_met    <= 1'b0;
        out_none   <= 1'b0;
      end else begin
        out_handle <= '0;
        out_met    <= 1'b0;
        out_none   <= 1'b1;
      end
    end
  end

  assign result.valid         = out_v;
  assign result.chosen_handle = out_handle;
  assign result.met_property  = out_met;
  assign result.nothing_left  = out_none;

endmodule

// File: src/fbs_leader.sv
// ----------------------------------------------------------------------------
// fbs_leader: running best candidate
// Holds one leader, compares each offered candidate against it and reports
// the leader as it stands once the offered candidate is counted.
// ----------------------------------------------------------------------------
module fbs_leader (
  input  logic           clk,
  input  logic           rst,
  input  fbs_pkg::cand_t cand,
  input  logic           take,
  input  logic           clear,
  output fbs_pkg::lead_t next_lead
);

  logic           valid;
  fbs_pkg::cand_t held;
  logic           upd;

  assign upd = take && (!valid || fbs_pkg::ranks_ahead(cand, held));

  assign next_lead.valid  = valid || take;
  assign next_lead.handle = upd ? cand.handle : held.handle;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (upd) begin
      valid <= 1'b1;
    end
    if (upd) begin
      held <= cand;
    end
  end

endmodule

// File: src/fbs_checker.sv
// ----------------------------------------------------------------------------
// fbs_checker: port-level checks of the best-entry selector
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module fbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [fbs_pkg::HANDLE_W-1:0] res_handle,
  input logic                         res_met,
  input logic                         res_none
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // an empty set reports a zero handle and no property
  a_empty_set: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_none |-> res_handle == '0 && !res_met)
    else $error("empty-set result carries a winner");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable(res_handle) && $stable(res_met) && $stable(res_none))
    else $error("result payload changed while stalled");

endmodule

bind filtered_lexicographic_best_select_top fbs_checker u_fbs_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_handle (result.chosen_handle),
  .res_met    (result.met_property),
  .res_none   (result.nothing_left)
);

// File: verif/tb_filtered_lexicographic_best_select_top.sv
// ----------------------------------------------------------------------------
// tb_filtered_lexicographic_best_select_top: selector testbench
// Streams sets of candidate entries under several filter and weighting
// settings, predicts the winner of each set, and checks every result item
// field by field against the predicted winners in order.
// ----------------------------------------------------------------------------
module tb_filtered_lexicographic_best_select_top;
  import fbs_pkg::*;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [CLUSTER_W-1:0] clusters;
    logic [DIM_W-1:0]     dim;
    logic [LEAF_W-1:0]    leaves;
    logic [PSUM_W-1:0]    psum;
    logic                 last;
  } cand_entry_t;

  typedef struct packed {
    logic                   valid;
    logic [HANDLE_W-1:0]    handle;
    logic [PRIMARY_W-1:0]   primary;
    logic [SECONDARY_W-1:0] secondary;
    logic [CLUSTER_W-1:0]   clusters;
  } leader_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                met;
    logic                empty;
  } selection_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_pattern_t;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int PHASE_ITEMS   = 115;
  localparam int HOLDOFF_CYCLES = 300;

  logic clk;
  logic rst;

  fbs_in_if  entry_ch ();
  fbs_cfg_if cfg_ch ();
  fbs_out_if result_ch ();

  filtered_lexicographic_best_select_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  cand_entry_t        pending_entries[$];
  selection_t         expected_winners[$];
  leader_t            best_overall;
  leader_t            best_preferred;
  logic [BOUND_W-1:0] cur_bound;
  logic               cur_weight;
  int                 mismatch_count;
  bit                 holdoff_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_filtered_lexicographic_best_select_top: FAIL");
    $finish;
  end

  // Strictly ahead: lower primary, then lower secondary, then more clusters.
  function automatic bit outranks(logic [PRIMARY_W-1:0] p, logic [SECONDARY_W-1:0] s,
                                  logic [CLUSTER_W-1:0] c, leader_t held);
    if (p != held.primary) return p < held.primary;
    if (s != held.secondary) return s < held.secondary;
    return c > held.clusters;
  endfunction

  function automatic void fold_entry(cand_entry_t e);
    logic [PRIMARY_W-1:0]   primary;
    logic [SECONDARY_W-1:0] secondary;
    logic [HANDLE_W-1:0]    handle;
    logic                   keep;
    logic                   prop;
    selection_t             pick;
    handle = HANDLE_W'(HANDLE_BITS'(e.handle));
    keep = (cur_bound == '0) || ({16'd0, e.dim} < (32'd1 << cur_bound));
    if (keep) begin
      primary   = cur_weight ? PRIMARY_W'(e.psum) * PRIMARY_W'(e.dim) : PRIMARY_W'(e.psum);
      secondary = SECONDARY_W'(e.clusters) * SECONDARY_W'(e.leaves);
      prop      = {16'd0, e.dim} < (32'd1 << e.leaves);
      if (!best_overall.valid || outranks(primary, secondary, e.clusters, best_overall)) begin
        best_overall = '{1'b1, handle, primary, secondary, e.clusters};
      end
      if (prop && (!best_preferred.valid ||
                   outranks(primary, secondary, e.clusters, best_preferred))) begin
        best_preferred = '{1'b1, handle, primary, secondary, e.clusters};
      end
    end
    if (e.last) begin
      if (best_preferred.valid) begin
        pick = '{best_preferred.handle, 1'b1, 1'b0};
      end else if (best_overall.valid) begin
        pick = '{best_overall.handle, 1'b0, 1'b0};
      end else begin
        pick = '{'0, 1'b0, 1'b1};
      end
      expected_winners.push_back(pick);
      best_overall   = '0;
      best_preferred = '0;
    end
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------- driver
  int          gap_left;
  int          burst_left;
  cand_entry_t cur_item;

  always @(posedge clk) begin : drive_entries
    bit offer;
    if (rst) begin
      entry_ch.valid <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (entry_ch.valid && entry_ch.ready) begin
        fold_entry(cur_item);
      end
      // hold an item that has not been taken yet
      if (!(entry_ch.valid && !entry_ch.ready)) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_entries.size() != 0) begin
          cur_item = pending_entries.pop_front();
          offer    = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left--;
          end
        end
        entry_ch.valid <= offer;
        if (offer) begin
          entry_ch.entry_handle    <= cur_item.handle;
          entry_ch.cluster_count   <= cur_item.clusters;
          entry_ch.largest_dim     <= cur_item.dim;
          entry_ch.leaf_limit      <= cur_item.leaves;
          entry_ch.dim_product_sum <= cur_item.psum;
          entry_ch.final_entry     <= cur_item.last;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  rx_pattern_t rx_pattern;
  int          pattern_left;
  int          holdoff_left;
  bit          holdoff_done;
  int unsigned rx_cycle;

  always @(posedge clk) begin : collect_results
    selection_t want;
    logic       rdy;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_pattern   = RX_OPEN;
      pattern_left = 0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      rx_cycle     = 0;
    end else begin
      rx_cycle++;
      if (result_ch.valid && result_ch.ready) begin
        if (expected_winners.size() == 0) begin
          note_mismatch("unexpected result, handle", 32'd0, 32'(result_ch.chosen_handle));
        end else begin
          want = expected_winners.pop_front();
          if (result_ch.chosen_handle !== want.handle)
            note_mismatch("chosen_handle", 32'(want.handle), 32'(result_ch.chosen_handle));
          if (result_ch.met_property !== want.met)
            note_mismatch("met_property", 32'(want.met), 32'(result_ch.met_property));
          if (result_ch.nothing_left !== want.empty)
            note_mismatch("nothing_left", 32'(want.empty), 32'(result_ch.nothing_left));
        end
      end
      if (holdoff_req && !holdoff_done) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rdy = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          rx_pattern   = rx_pattern_t'(2'($urandom_range(3, 0)));
          pattern_left = $urandom_range(80, 16);
        end else begin
          pattern_left--;
        end
        case (rx_pattern)
          RX_OPEN:     rdy = 1'b1;
          RX_COIN:     rdy = 1'($urandom_range(1, 0));
          RX_SPARSE:   rdy = ($urandom_range(3, 0) == 0);
          default:     rdy = (rx_cycle % 3 == 0);
        endcase
      end
      result_ch.ready <= rdy;
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_BOUND_EXPONENT) begin
      cur_bound = value[BOUND_W-1:0];
    end else if (idx == CFG_WEIGHT_BY_DIM) begin
      cur_weight = value[0];
    end
  endtask

  // Upper data bits carry noise; only the low field bits matter.
  task automatic configure(logic [BOUND_W-1:0] bound, logic weight);
    write_reg(CFG_BOUND_EXPONENT, ($urandom & ~32'h1F) | 32'(bound));
    write_reg(CFG_WEIGHT_BY_DIM, ($urandom & ~32'h1) | 32'(weight));
  endtask

  task automatic drain();
    while (pending_entries.size() != 0 || entry_ch.valid || expected_winners.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic void add_entry(logic [15:0] h, logic [9:0] c, logic [15:0] d,
                                    logic [4:0] l, logic [23:0] p, logic f);
    pending_entries.push_back('{h, c, d, l, p, f});
  endfunction

  // Keys are drawn from narrow ranges often, so ties on every level come up.
  function automatic int queue_random_set();
    int          len;
    int          k;
    cand_entry_t e;
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      e.handle   = 16'($urandom);
      e.clusters = ($urandom_range(1, 0) == 0) ? 10'($urandom_range(7, 0)) : 10'($urandom);
      k = $urandom_range(16, 0);
      case ($urandom_range(4, 0))
        0: e.dim = 16'($urandom_range(15, 0));
        1: e.dim = 16'($urandom);
        2: e.dim = 16'((32'd1 << k) - $urandom_range(1, 0));
        3: e.dim = 16'((32'd1 << cur_bound) - $urandom_range(1, 0));
        default: e.dim = 16'($urandom_range(255, 0));
      endcase
      e.leaves = 5'($urandom_range(31, 0));
      e.psum   = ($urandom_range(2, 0) == 0) ? 24'($urandom) : 24'($urandom_range(3, 0));
      e.last   = (i == len - 1);
      pending_entries.push_back(e);
    end
    return len;
  endfunction

  initial begin : run_test
    logic [BOUND_W-1:0] bound_plan [10];
    logic               weight_plan[10];
    int                 random_items;
    int                 phase_items;
    int                 phase;
    bound_plan  = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd8, 5'd0, 5'd12, 5'd3, 5'd31};
    weight_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    rst            = 1'b1;
    mismatch_count = 0;
    holdoff_req    = 1'b0;
    cur_bound      = '0;
    cur_weight     = 1'b0;
    best_overall   = '0;
    best_preferred = '0;
    entry_ch.valid           = 1'b0;
    entry_ch.entry_handle    = '0;
    entry_ch.cluster_count   = '0;
    entry_ch.largest_dim     = '0;
    entry_ch.leaf_limit      = '0;
    entry_ch.dim_product_sum = '0;
    entry_ch.final_entry     = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = CFG_BOUND_EXPONENT;
    cfg_ch.data              = '0;
    result_ch.ready          = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no filter, plain primary key
    configure(5'd0, 1'b0);
    add_entry(16'hFFFF, 10'h3FF, 16'hFFFF, 5'd31, 24'hFFFFFF, 1'b1);
    add_entry(16'h0000, 10'h000, 16'h0000, 5'd0, 24'h000000, 1'b1);
    // full tie keeps the earlier entry
    add_entry(16'h0011, 10'd5, 16'd100, 5'd3, 24'd50, 1'b0);
    add_entry(16'h0022, 10'd5, 16'd100, 5'd3, 24'd50, 1'b0);
    add_entry(16'h0033, 10'd5, 16'd100, 5'd3, 24'd60, 1'b1);
    // equal secondary, more clusters wins
    add_entry(16'h0101, 10'd4, 16'd300, 5'd6, 24'd7, 1'b0);
    add_entry(16'h0202, 10'd8, 16'd300, 5'd3, 24'd7, 1'b0);
    add_entry(16'h0303, 10'd2, 16'd300, 5'd20, 24'd7, 1'b1);
    // preferred leader beats a better overall leader
    add_entry(16'h0A0A, 10'd1, 16'd1000, 5'd5, 24'd10, 1'b0);
    add_entry(16'h0B0B, 10'd1, 16'd3, 5'd2, 24'd900, 1'b1);
    add_entry(16'h0C0C, 10'd1, 16'd16, 5'd4, 24'd5, 1'b1);
    drain();

    // filter at 16, weighted key
    configure(5'd4, 1'b1);
    add_entry(16'h1111, 10'd1, 16'd16, 5'd31, 24'd1, 1'b0);
    add_entry(16'h2222, 10'd1, 16'hFFFF, 5'd31, 24'd0, 1'b1);
    add_entry(16'h3333, 10'd2, 16'd15, 5'd4, 24'd10, 1'b0);
    add_entry(16'h4444, 10'd2, 16'd16, 5'd31, 24'd0, 1'b0);
    add_entry(16'h5555, 10'd3, 16'd1, 5'd0, 24'd100, 1'b1);
    add_entry(16'h6666, 10'd1, 16'd0, 5'd0, 24'hFFFFFF, 1'b0);
    add_entry(16'h7777, 10'd1, 16'd2, 5'd0, 24'd1, 1'b1);
    drain();

    // widest weighted products
    configure(5'd0, 1'b1);
    add_entry(16'h8888, 10'd1, 16'hFFFF, 5'd0, 24'hFFFFFF, 1'b0);
    add_entry(16'h9999, 10'd1, 16'hFFFF, 5'd0, 24'hFFFFFE, 1'b0);
    add_entry(16'hAAAA, 10'd1, 16'hFFFE, 5'd0, 24'hFFFFFF, 1'b1);
    drain();

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase < 10) begin
        configure(bound_plan[phase], weight_plan[phase]);
      end else begin
        configure(5'($urandom_range(31, 0)), 1'($urandom_range(1, 0)));
      end
      if (phase == 2 || phase == 6) begin
        write_reg(cfg_reg_t'(CFG_INDEX_W'($urandom_range(15, 2))), $urandom);
      end
      // long receiver hold-off while the sender keeps going
      if (phase == 3) holdoff_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) phase_items += queue_random_set();
      random_items += phase_items;
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_winners.size() == 0) begin
      $display("tb_filtered_lexicographic_best_select_top: PASS");
    end else begin
      $display("tb_filtered_lexicographic_best_select_top: FAIL");
    end
    $finish;
  end

endmodule
